/* hw/rtl/itf_pkg.sv */
// Shared types, codes and port widths for the interval timer.
package itf_pkg;

  // Fixed widths of the stream and configuration ports.
  localparam int unsigned FieldTimeW = 32;
  localparam int unsigned InTdataW   = 64;
  localparam int unsigned InTuserW   = 2;
  localparam int unsigned OutTdataW  = 40;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 32;

  // Timer state codes.
  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_OVER    = 2'd2;

  // Item modes carried in tuser.
  localparam logic [1:0] MODE_RUN       = 2'd0;
  localparam logic [1:0] MODE_RESET     = 2'd1;
  localparam logic [1:0] MODE_SET_START = 2'd2;
  localparam logic [1:0] MODE_CLEAR_END = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_DURATION       = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_AUTO_RESET     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_FREQUENCY_MODE = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_EXTERNAL_START = 2'd3;

  // Reset value of the duration register in milliseconds.
  localparam logic [CfgDataW-1:0] DURATION_RST = 32'd1000;

  // Control state of the timer.
  typedef struct packed {
    logic [1:0] state;
    logic       starting;
    logic       ending;
    logic       start_known;
  } itf_flags_t;

  // Single-bit configuration registers.
  typedef struct packed {
    logic auto_reset;
    logic frequency_mode;
    logic external_start;
  } itf_cfg_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic [FieldTimeW-1:0] elapsed;
    logic                  ending;
    logic                  starting;
    logic [1:0]            state_code;
    logic                  running_result;
  } itf_item_t;

endpackage

/* hw/rtl/itf_step.sv */
// Next-state and result logic of the interval timer for one item.
module itf_step import itf_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic [1:0]            mode_i,
  input  logic [TIME_WIDTH-1:0] now_i,
  input  logic [TIME_WIDTH-1:0] start_value_i,
  input  logic [TIME_WIDTH-1:0] start_q_i,
  input  logic [TIME_WIDTH-1:0] duration_i,
  input  itf_flags_t            flags_i,
  input  itf_cfg_t              cfg_i,
  output logic [TIME_WIDTH-1:0] start_d_o,
  output itf_flags_t            flags_d_o,
  output itf_item_t             result_o
);

  logic [TIME_WIDTH-1:0] elapsed_run;
  logic [TIME_WIDTH-1:0] elapsed_new;
  logic                  run_res;

  // Elapsed time against the stored start, wrapping.
  assign elapsed_run = now_i - start_q_i;

  // State update for the item's mode.
  always_comb begin
    flags_d_o = flags_i;
    start_d_o = start_q_i;
    run_res   = 1'b0;
    unique case (mode_i)
      MODE_RUN: begin
        unique case (flags_i.state)
          ST_READY: begin
            if (!cfg_i.external_start) begin
              if (cfg_i.frequency_mode && flags_i.start_known) begin
                start_d_o = start_q_i + duration_i;
              end else begin
                start_d_o = now_i;
              end
            end
            flags_d_o.start_known = 1'b1;
            flags_d_o.state       = ST_RUNNING;
            flags_d_o.starting    = 1'b1;
            flags_d_o.ending      = 1'b0;
            run_res               = 1'b1;
          end
          ST_RUNNING: begin
            flags_d_o.starting = 1'b0;
            run_res            = 1'b1;
            if (elapsed_run >= duration_i) begin
              flags_d_o.ending = 1'b1;
              if (cfg_i.auto_reset || cfg_i.frequency_mode) begin
                flags_d_o.state = ST_READY;
              end else begin
                flags_d_o.state = ST_OVER;
                run_res         = 1'b0;
              end
            end
          end
          default: begin
            flags_d_o.ending = 1'b0;
          end
        endcase
      end
      MODE_RESET: begin
        flags_d_o.state = ST_READY;
      end
      MODE_SET_START: begin
        if (flags_i.state == ST_READY && cfg_i.external_start) begin
          start_d_o             = start_value_i;
          flags_d_o.start_known = 1'b1;
        end
      end
      MODE_CLEAR_END: begin
        flags_d_o.ending = 1'b0;
      end
      default: begin
        flags_d_o = flags_i;
      end
    endcase
  end

  // Elapsed time against the start that holds after this item.
  assign elapsed_new = now_i - start_d_o;

  // Result item; the clear-ending mode reports the flag before clearing it.
  always_comb begin
    result_o.running_result = run_res;
    result_o.state_code     = flags_d_o.state;
    result_o.starting       = flags_d_o.starting;
    result_o.ending         = (mode_i == MODE_CLEAR_END) ? flags_i.ending : flags_d_o.ending;
    unique case (flags_d_o.state)
      ST_RUNNING: result_o.elapsed = FieldTimeW'(elapsed_new);
      ST_OVER:    result_o.elapsed = FieldTimeW'(duration_i);
      default:    result_o.elapsed = '0;
    endcase
  end

endmodule

/* hw/rtl/interval_timer_fsm_core.sv */
// Top level of the interval timer: stream ports, item registers and timer state.
//
// Interval timer with the states ready, running and over, stepped by one item
// per clock. Each input item carries a mode in tuser (run, reset to ready, set
// start time, read and clear ending) and the current millisecond time and a
// start value in tdata; each item yields exactly one result item. The block
// takes one item every cycle while results drain. An accepted item passes the
// input register, which holds it for the step logic, and then the result
// register, which captures the outcome and offers it. A stalled result blocks
// the input register and with it the input. Time arithmetic wraps modulo
// 2^TIME_WIDTH. The user must write configuration through the cfg port only
// while no item is in flight; the block itself does not enforce this. Duration
// and auto_reset only take effect when written in the ready state.
module interval_timer_fsm_core import itf_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input items.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // now [31:0], start_value [63:32]
  input  logic [InTuserW-1:0]  s_axis_tuser,   // mode [1:0]
  // Result items.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,   // running_result [0], state_code [2:1],
                                               // starting [3], ending [4], elapsed [36:5],
                                               // zero [39:37]
  // Configuration writes.
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  logic                  s_accept;
  logic                  adv;

  logic                  s1_valid_q;
  logic [1:0]            s1_mode_q;
  logic [TIME_WIDTH-1:0] s1_now_q;
  logic [TIME_WIDTH-1:0] s1_sval_q;

  logic                  m_valid_q;
  logic [OutTdataW-1:0]  m_data_q;

  logic [TIME_WIDTH-1:0] duration_q;
  itf_cfg_t              cfg_q;
  itf_flags_t            flags_q;
  logic [TIME_WIDTH-1:0] start_q;

  logic [TIME_WIDTH-1:0] start_d;
  itf_flags_t            flags_d;
  itf_item_t             result;

  // Handshake: the step advances when the result register is free or drains.
  assign adv           = s1_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || adv;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Input register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_accept) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_mode_q <= s_axis_tuser;
      s1_now_q  <= TIME_WIDTH'(s_axis_tdata[FieldTimeW-1:0]);
      s1_sval_q <= TIME_WIDTH'(s_axis_tdata[2*FieldTimeW-1:FieldTimeW]);
    end
  end

  // Step logic.
  itf_step #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_itf_step (
    .mode_i        (s1_mode_q),
    .now_i         (s1_now_q),
    .start_value_i (s1_sval_q),
    .start_q_i     (start_q),
    .duration_i    (duration_q),
    .flags_i       (flags_q),
    .cfg_i         (cfg_q),
    .start_d_o     (start_d),
    .flags_d_o     (flags_d),
    .result_o      (result)
  );

  // Timer state, updated as each item leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '{state: ST_READY, default: 1'b0};
      start_q <= '0;
    end else if (adv) begin
      flags_q <= flags_d;
      start_q <= start_d;
    end
  end

  // Configuration registers; duration and auto_reset take only in ready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duration_q <= TIME_WIDTH'(DURATION_RST);
      cfg_q      <= '{auto_reset: 1'b1, default: 1'b0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DURATION: begin
          if (flags_q.state == ST_READY) begin
            duration_q <= TIME_WIDTH'(cfg_data_i);
          end
        end
        REG_AUTO_RESET: begin
          if (flags_q.state == ST_READY) begin
            cfg_q.auto_reset <= cfg_data_i[0];
          end
        end
        REG_FREQUENCY_MODE: cfg_q.frequency_mode <= cfg_data_i[0];
        REG_EXTERNAL_START: cfg_q.external_start <= cfg_data_i[0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_data_q <= OutTdataW'(result);
    end
  end

endmodule

/* hw/rtl/itf_checker.sv */
// Port-level checker for the interval timer and its bind to the top level.
module itf_checker import itf_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata
);

  logic [1:0] out_state;
  logic       out_result;
  logic       out_ending;

  assign out_result = m_axis_tdata[0];
  assign out_state  = m_axis_tdata[2:1];
  assign out_ending = m_axis_tdata[4];

  // A stalled result item holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  // A timer that is over never reports a running result.
  a_over_not_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_state == ST_OVER |-> !out_result)
    else $error("running result reported in over state");

  // In ready the elapsed time reads as zero.
  a_ready_elapsed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_state == ST_READY |-> m_axis_tdata[36:5] == 32'd0)
    else $error("nonzero elapsed time in ready state");

  // A running result in ready only follows an expiry, which raises ending.
  a_expiry_ending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_state == ST_READY && out_result |-> out_ending)
    else $error("return to ready without ending flag");

endmodule

bind interval_timer_fsm_core itf_checker u_itf_checker (.*);

/* test/interval_timer_fsm_core_tb.sv */
// Self-checking testbench for the interval timer core: directed and random items.
`timescale 1ns / 1ps

module interval_timer_fsm_core_tb;
  import itf_pkg::*;

  // Mirror of the timer: tracks state and registers, predicts one result per item.
  class itf_timer_mirror;
    logic [31:0] dur;
    logic        auto_rst;
    logic        freq_mode;
    logic        ext_start;
    logic [1:0]  state;
    logic [31:0] start_t;
    logic        starting_f;
    logic        ending_f;
    logic        start_known;
    itf_item_t   pending_results[$];
    int          mismatch_cnt;

    function new();
      dur          = DURATION_RST;
      auto_rst     = 1'b1;
      freq_mode    = 1'b0;
      ext_start    = 1'b0;
      state        = ST_READY;
      start_t      = '0;
      starting_f   = 1'b0;
      ending_f     = 1'b0;
      start_known  = 1'b0;
      mismatch_cnt = 0;
    endfunction

    // Duration and auto_reset only take while the timer is ready.
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_DURATION:       if (state == ST_READY) dur = data;
        REG_AUTO_RESET:     if (state == ST_READY) auto_rst = data[0];
        REG_FREQUENCY_MODE: freq_mode = data[0];
        REG_EXTERNAL_START: ext_start = data[0];
        default: ;
      endcase
    endfunction

    // One run step; returns the running result bit.
    function logic run_step(logic [31:0] now);
      if (state == ST_READY) begin
        if (!ext_start) begin
          if (freq_mode && start_known) start_t = start_t + dur;
          else start_t = now;
        end
        start_known = 1'b1;
        state       = ST_RUNNING;
        starting_f  = 1'b1;
        ending_f    = 1'b0;
        return 1'b1;
      end
      if (state == ST_RUNNING) begin
        starting_f = 1'b0;
        if (now - start_t >= dur) begin
          ending_f = 1'b1;
          if (auto_rst || freq_mode) begin
            state = ST_READY;
            return 1'b1;
          end
          state = ST_OVER;
          return 1'b0;
        end
        return 1'b1;
      end
      ending_f = 1'b0;
      return 1'b0;
    endfunction

    // Called for every accepted input item.
    function void note_step(logic [1:0] mode, logic [31:0] now, logic [31:0] sval);
      itf_item_t r;
      r = '0;
      case (mode)
        MODE_RUN:   r.running_result = run_step(now);
        MODE_RESET: state = ST_READY;
        MODE_SET_START: begin
          if (state == ST_READY && ext_start) begin
            start_t     = sval;
            start_known = 1'b1;
          end
        end
        default: ;
      endcase
      // The clear-ending mode reports the flag before clearing it.
      r.ending = ending_f;
      if (mode == MODE_CLEAR_END) ending_f = 1'b0;
      r.state_code = state;
      r.starting   = starting_f;
      if (state == ST_RUNNING) r.elapsed = now - start_t;
      else if (state == ST_OVER) r.elapsed = dur;
      else r.elapsed = '0;
      pending_results.push_back(r);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        mismatch_cnt++;
      end
    endfunction

    // Called for every accepted result item.
    function void check_result(logic [OutTdataW-1:0] tdata);
      itf_item_t got;
      itf_item_t want;
      got = tdata[$bits(itf_item_t)-1:0];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, tdata);
        mismatch_cnt++;
        return;
      end
      want = pending_results.pop_front();
      check_field("running_result", 32'(want.running_result), 32'(got.running_result));
      check_field("state_code", 32'(want.state_code), 32'(got.state_code));
      check_field("starting", 32'(want.starting), 32'(got.starting));
      check_field("ending", 32'(want.ending), 32'(got.ending));
      check_field("elapsed", want.elapsed, got.elapsed);
      check_field("tdata padding", 32'd0, 32'(tdata[OutTdataW-1:$bits(itf_item_t)]));
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic [InTuserW-1:0]  s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  itf_timer_mirror mirror = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  interval_timer_fsm_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Result side: check accepted items and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) mirror.check_result(m_axis_tdata);
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Offer one item, with random idle cycles first, and wait until it is taken.
  task automatic send_item(logic [1:0] mode, logic [31:0] now, logic [31:0] sval);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sval, now};
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    mirror.note_step(mode, now, sval);
  endtask

  // Stop sending, let every outstanding result arrive, then allow for the pipeline.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register writes happen only with the block idle.
  task automatic set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    mirror.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Single-bit registers get random upper bits, which the block must ignore.
  function automatic logic [CfgDataW-1:0] flag_word(logic bit_val);
    return ($urandom() & 32'hFFFF_FFFE) | 32'(bit_val);
  endfunction

  task automatic directed_items();
    // First run in frequency mode latches now, later runs advance by duration.
    set_reg(REG_FREQUENCY_MODE, flag_word(1'b1));
    send_item(MODE_RUN, 32'd100, 32'd0);
    send_item(MODE_RUN, 32'd1100, 32'd0);
    send_item(MODE_RUN, 32'd2050, 32'd0);
    send_item(MODE_CLEAR_END, 32'd2050, 32'd0);
    set_reg(REG_FREQUENCY_MODE, flag_word(1'b0));
    // Reset keeps the flags; set start is refused without external start.
    send_item(MODE_RESET, 32'd0, 32'd0);
    send_item(MODE_SET_START, 32'd0, 32'h1234_5678);
    // Elapsed time across the wrap of the millisecond counter.
    send_item(MODE_RUN, 32'hFFFF_FF00, 32'd0);
    send_item(MODE_RUN, 32'h0000_0100, 32'd0);
    send_item(MODE_RUN, 32'h0000_02E8, 32'd0);
    send_item(MODE_CLEAR_END, 32'd0, 32'd0);
    // Stop in over; duration and auto_reset writes are ignored while running.
    set_reg(REG_AUTO_RESET, flag_word(1'b0));
    send_item(MODE_RUN, 32'd0, 32'd0);
    set_reg(REG_DURATION, 32'd5);
    set_reg(REG_AUTO_RESET, flag_word(1'b1));
    send_item(MODE_RUN, 32'd999, 32'd0);
    send_item(MODE_RUN, 32'd1000, 32'd0);
    send_item(MODE_RUN, 32'd5, 32'd0);
    send_item(MODE_RESET, 32'd0, 32'd0);
    // External start with the largest duration; set start refused in over.
    set_reg(REG_DURATION, 32'hFFFF_FFFF);
    set_reg(REG_EXTERNAL_START, flag_word(1'b1));
    send_item(MODE_SET_START, 32'd0, 32'hFFFF_FFFF);
    send_item(MODE_RUN, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_item(MODE_RUN, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_item(MODE_SET_START, 32'd0, 32'd0);
    send_item(MODE_RESET, 32'd0, 32'd0);
    // Zero duration expires on the first step in running.
    set_reg(REG_DURATION, 32'd0);
    set_reg(REG_EXTERNAL_START, flag_word(1'b0));
    set_reg(REG_AUTO_RESET, flag_word(1'b1));
    send_item(MODE_RUN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(MODE_RUN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(MODE_CLEAR_END, 32'd0, 32'd0);
  endtask

  // One random phase: new settings, then mostly run steps on an advancing clock.
  task automatic random_phase(int phase, int n_items);
    logic [31:0] dur;
    logic [31:0] wall_ms;
    logic [31:0] sval;
    logic [1:0]  mode;
    int          step_max;
    int          pick;
    case (phase)
      0:       dur = 32'd0;
      1:       dur = 32'hFFFF_FFFF;
      2:       dur = 32'd1000;
      default: dur = $urandom_range(1, 60);
    endcase
    if ($urandom_range(0, 1) == 1) send_item(MODE_RESET, $urandom(), $urandom());
    set_reg(REG_DURATION, dur);
    set_reg(REG_AUTO_RESET, flag_word(1'($urandom_range(0, 1))));
    set_reg(REG_FREQUENCY_MODE, flag_word(phase % 3 == 0));
    set_reg(REG_EXTERNAL_START, flag_word($urandom_range(0, 3) == 0));
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
      default: begin send_idle_pct = 36; recv_stall_pct = 36; end
    endcase
    wall_ms  = (phase == 5) ? 32'hFFFF_F000 : $urandom();
    step_max = (mirror.dur > 32'd4000) ? 2000 : int'(mirror.dur / 2) + 2;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // Noise: any mode with unrelated times.
        send_item(2'($urandom_range(0, 3)), $urandom(), $urandom());
      end else begin
        wall_ms = wall_ms + $urandom_range(0, step_max);
        pick = $urandom_range(0, 99);
        if (pick < 78) mode = MODE_RUN;
        else if (pick < 84) mode = MODE_RESET;
        else if (pick < 92) mode = MODE_SET_START;
        else mode = MODE_CLEAR_END;
        if ($urandom_range(0, 1) == 1) sval = wall_ms - $urandom_range(0, step_max * 2);
        else sval = $urandom();
        send_item(mode, wall_ms, sval);
      end
      // Now and then hold off until the block has drained.
      if ($urandom_range(0, 149) == 0) settle();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_items();
    for (int p = 0; p < 8; p++) random_phase(p, 230);
    settle();
    repeat (10) @(posedge clk_i);
    if (mirror.pending() != 0)
      $display("%0t: %0d results never arrived", $time, mirror.pending());
    if (mirror.mismatch_cnt == 0 && mirror.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
